@@ src/bc_pkg.sv @@
// Shared constants, types and helper functions of the barometer compensation block.
package bc_pkg;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_T1    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_T2_T3 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_P1    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_P2_P3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_P4_P5 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_P6_P7 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_P8_P9 = 3'd6;

	localparam int DIV_STEPS  = 64;
	localparam int PIPE_DEPTH = 85;

	localparam logic [63:0] T_FINE_OFS = 64'd128000;
	localparam logic [63:0] P_FULL     = 64'd1048576;
	localparam logic [63:0] P_SCALE    = 64'd3125;
	localparam logic [63:0] P1_BIAS    = 64'h0000_8000_0000_0000;

	typedef struct packed {
		logic [15:0] temp_centi;
		logic        invalid;
	} bc_side_t;

	function automatic logic [31:0] sext16_32(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [63:0] sext16_64(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic logic [15:0] sat_temp(input logic [31:0] tc);
		logic [15:0] r;
		if ($signed(tc) < -32'sd32768) r = 16'h8000;
		else if ($signed(tc) > 32'sd32767) r = 16'h7FFF;
		else r = tc[15:0];
		return r;
	endfunction

	function automatic logic [31:0] sat_pres(input logic [63:0] p);
		logic [31:0] r;
		if (p[63]) r = 32'd0;
		else if (p[62:32] != '0) r = 32'hFFFF_FFFF;
		else r = p[31:0];
		return r;
	endfunction

endpackage

@@ src/barometer_compensation.sv @@
// Top level of the barometer compensation pipeline.
//
//  channel   signals                                         direction
//  -------   ----------------------------------------------  ---------
//  input     in_valid/in_ready, raw_temp, raw_pressure       request in
//  output    out_valid/out_ready, temp_centi,                request out
//            pressure_q24_8, pressure_invalid
//  config    cfg_valid/cfg_ready, cfg_index, cfg_data        request in
//
// One request enters per cycle while no result waits on out_ready; results leave in order
// through the 85-stage pipeline (temperature, 64-bit multiplies, 66-stage divider).
// Reset clears the calibration registers and all stage valid bits; data is unreset.
// The whole pipeline advances as one: when a result waits on out_ready, every
// stage holds, so no request is dropped or repeated. Configuration is always ready.
module barometer_compensation (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [19:0]                  raw_temp,
	input  logic [19:0]                  raw_pressure,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [15:0]                  temp_centi,
	output logic [31:0]                  pressure_q24_8,
	output logic                         pressure_invalid,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [bc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                  cfg_data
);

	// calibration words
	logic [15:0] cal_t1_q;
	logic [31:0] cal_t2_t3_q;
	logic [15:0] cal_p1_q;
	logic [31:0] cal_p2_p3_q;
	logic [31:0] cal_p4_p5_q;
	logic [31:0] cal_p6_p7_q;
	logic [31:0] cal_p8_p9_q;

	logic                          adv;
	logic [bc_pkg::PIPE_DEPTH:1]   vld_q;

	logic [19:0] raw_temp_s1;
	logic [19:0] raw_pressure_s [1:10];
	logic [31:0] m1_s2, m2_s2;
	logic [31:0] a1_s3, m3_s3;
	logic [31:0] tf_s4;
	logic [63:0] v1_s5;
	logic [15:0] temp_s [5:13];
	logic [63:0] x_s7, y_s7, z_s7;
	logic [63:0] y_s8, z_s8, y_s9, z_s9;
	logic [63:0] v2a_s9, w_s9;
	logic [63:0] v2_s10, u_s10;
	logic [63:0] nb_s11;
	logic [63:0] q_s12;
	logic [63:0] num_s13;
	logic [63:0] den_s13;

	logic [63:0]      quot_s79;
	bc_pkg::bc_side_t side_s79;
	bc_pkg::bc_side_t side_s [80:84];
	logic [63:0] p13_s80, p13_s81;
	logic [63:0] quot_s80, quot_s81, quot_s82, quot_s83;
	logic [63:0] ma_s81, mb_s81, mb_s82, mb_s83, mc_s83;
	logic [63:0] sum_s84;
	logic [15:0] temp_s85;
	logic [31:0] pres_s85;
	logic        inv_s85;

	logic [31:0] d1, d2, t2, t3, tc;
	logic [63:0] p2, p3, p4, p5, p6, p7, p8, p9, p1, p13;
	logic [63:0] pr;

	assign t2 = bc_pkg::sext16_32(cal_t2_t3_q[15:0]);
	assign t3 = bc_pkg::sext16_32(cal_t2_t3_q[31:16]);
	assign p1 = {48'd0, cal_p1_q};
	assign p2 = bc_pkg::sext16_64(cal_p2_p3_q[15:0]);
	assign p3 = bc_pkg::sext16_64(cal_p2_p3_q[31:16]);
	assign p4 = bc_pkg::sext16_64(cal_p4_p5_q[15:0]);
	assign p5 = bc_pkg::sext16_64(cal_p4_p5_q[31:16]);
	assign p6 = bc_pkg::sext16_64(cal_p6_p7_q[15:0]);
	assign p7 = bc_pkg::sext16_64(cal_p6_p7_q[31:16]);
	assign p8 = bc_pkg::sext16_64(cal_p8_p9_q[15:0]);
	assign p9 = bc_pkg::sext16_64(cal_p8_p9_q[31:16]);

	// configuration writes; unknown indexes are ignored
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_t1_q    <= '0;
			cal_t2_t3_q <= '0;
			cal_p1_q    <= '0;
			cal_p2_p3_q <= '0;
			cal_p4_p5_q <= '0;
			cal_p6_p7_q <= '0;
			cal_p8_p9_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				bc_pkg::CFG_T1:    cal_t1_q    <= cfg_data[15:0];
				bc_pkg::CFG_T2_T3: cal_t2_t3_q <= cfg_data;
				bc_pkg::CFG_P1:    cal_p1_q    <= cfg_data[15:0];
				bc_pkg::CFG_P2_P3: cal_p2_p3_q <= cfg_data;
				bc_pkg::CFG_P4_P5: cal_p4_p5_q <= cfg_data;
				bc_pkg::CFG_P6_P7: cal_p6_p7_q <= cfg_data;
				bc_pkg::CFG_P8_P9: cal_p8_p9_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance everything unless the last stage holds an untaken result
	assign adv      = !vld_q[bc_pkg::PIPE_DEPTH] || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[bc_pkg::PIPE_DEPTH-1:1], in_valid};
		end
	end

	// temperature path, 32-bit wrapping
	assign d1 = 32'(raw_temp_s1[19:3]) - 32'({cal_t1_q, 1'b0});
	assign d2 = 32'(raw_temp_s1[19:4]) - 32'(cal_t1_q);
	assign tc = 32'($signed(tf_s4 * 32'd5 + 32'd128) >>> 8);

	always_ff @(posedge clk) begin
		if (adv) begin
			raw_temp_s1       <= raw_temp;
			raw_pressure_s[1] <= raw_pressure;
			for (int i = 2; i <= 10; i++) raw_pressure_s[i] <= raw_pressure_s[i-1];
			m1_s2 <= d1 * t2;
			m2_s2 <= d2 * d2;
			a1_s3 <= 32'($signed(m1_s2) >>> 11);
			m3_s3 <= 32'($signed(m2_s2) >>> 12) * t3;
			tf_s4 <= a1_s3 + 32'($signed(m3_s3) >>> 14);
			temp_s[5] <= bc_pkg::sat_temp(tc);
			for (int i = 6; i <= 13; i++) temp_s[i] <= temp_s[i-1];
			v1_s5 <= {{32{tf_s4[31]}}, tf_s4} - bc_pkg::T_FINE_OFS;
			y_s8 <= y_s7;
			z_s8 <= z_s7;
			y_s9 <= y_s8;
			z_s9 <= z_s8;
			v2_s10 <= v2a_s9 + (y_s9 << 17) + (p4 << 35);
			u_s10  <= bc_pkg::P1_BIAS + 64'($signed(w_s9) >>> 8) + (z_s9 << 12);
			nb_s11 <= ((bc_pkg::P_FULL - 64'(raw_pressure_s[10])) << 31) - v2_s10;
			den_s13 <= 64'($signed(q_s12) >>> 33);
		end
	end

	// pressure path, 64-bit wrapping products
	bc_mul64 u_mul_x (.clk(clk), .en(adv), .a(v1_s5), .b(v1_s5), .prod(x_s7));
	bc_mul64 u_mul_y (.clk(clk), .en(adv), .a(v1_s5), .b(p5), .prod(y_s7));
	bc_mul64 u_mul_z (.clk(clk), .en(adv), .a(v1_s5), .b(p2), .prod(z_s7));
	bc_mul64 u_mul_v2 (.clk(clk), .en(adv), .a(x_s7), .b(p6), .prod(v2a_s9));
	bc_mul64 u_mul_w (.clk(clk), .en(adv), .a(x_s7), .b(p3), .prod(w_s9));
	bc_mul64 u_mul_q (.clk(clk), .en(adv), .a(u_s10), .b(p1), .prod(q_s12));
	bc_mul64 u_mul_n (.clk(clk), .en(adv), .a(nb_s11), .b(bc_pkg::P_SCALE),
		.prod(num_s13));

	bc_pkg::bc_side_t div_side;
	assign div_side = '{temp_centi: temp_s[13], invalid: (den_s13 == 64'd0)};

	bc_div u_div (
		.clk      (clk),
		.en       (adv),
		.num      (num_s13),
		.den      (den_s13),
		.side_in  (div_side),
		.quot     (quot_s79),
		.side_out (side_s79)
	);

	// final correction after the divide
	assign p13 = 64'($signed(quot_s79) >>> 13);

	bc_mul64 u_mul_a (.clk(clk), .en(adv), .a(p9), .b(p13), .prod(ma_s81));
	bc_mul64 u_mul_b (.clk(clk), .en(adv), .a(p8), .b(quot_s79), .prod(mb_s81));
	bc_mul64 u_mul_c (.clk(clk), .en(adv), .a(ma_s81), .b(p13_s81), .prod(mc_s83));

	assign pr = 64'($signed(sum_s84) >>> 8) + (p7 << 4);

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[80] <= side_s79;
			for (int i = 81; i <= 84; i++) side_s[i] <= side_s[i-1];
			p13_s80  <= p13;
			p13_s81  <= p13_s80;
			quot_s80 <= quot_s79;
			quot_s81 <= quot_s80;
			quot_s82 <= quot_s81;
			quot_s83 <= quot_s82;
			mb_s82   <= mb_s81;
			mb_s83   <= mb_s82;
			sum_s84  <= quot_s83 + 64'($signed(mc_s83) >>> 25) + 64'($signed(mb_s83) >>> 19);
			temp_s85 <= side_s[84].temp_centi;
			inv_s85  <= side_s[84].invalid;
			pres_s85 <= side_s[84].invalid ? 32'd0 : bc_pkg::sat_pres(pr);
		end
	end

	assign out_valid        = vld_q[bc_pkg::PIPE_DEPTH];
	assign temp_centi       = temp_s85;
	assign pressure_q24_8   = pres_s85;
	assign pressure_invalid = inv_s85;

	// a stall freezes the whole valid chain
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("valid chain moved during a stall");

	// input is refused only behind an untaken result
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input refused without output stall");

	// an accepted request occupies the first stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_q[1])
		else $error("accepted request lost at entry");

	// zero divisor forces zero pressure
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pressure_invalid) |-> (pressure_q24_8 == 32'd0))
		else $error("invalid result with nonzero pressure");

endmodule

@@ src/bc_mul64.sv @@
// Two-stage 64 by 64 multiplier giving the low 64 bits of the product.
module bc_mul64 (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] prod
);

	logic [63:0] pp_ll_s1;
	logic [31:0] pp_lh_s1;
	logic [31:0] pp_hl_s1;
	logic [63:0] prod_s2;

	// cross terms only matter in their low half once shifted up
	always_ff @(posedge clk) begin
		if (en) begin
			pp_ll_s1 <= 64'(a[31:0] * b[31:0]);
			pp_lh_s1 <= 32'(a[31:0] * b[63:32]);
			pp_hl_s1 <= 32'(a[63:32] * b[31:0]);
			prod_s2  <= pp_ll_s1 + {pp_lh_s1 + pp_hl_s1, 32'd0};
		end
	end

	assign prod = prod_s2;

endmodule

@@ src/bc_div.sv @@
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating toward zero.
module bc_div (
	input  logic             clk,
	input  logic             en,
	input  logic [63:0]      num,
	input  logic [63:0]      den,
	input  bc_pkg::bc_side_t side_in,
	output logic [63:0]      quot,
	output bc_pkg::bc_side_t side_out
);

	logic [63:0]      rem_s  [bc_pkg::DIV_STEPS+1];
	logic [63:0]      nq_s   [bc_pkg::DIV_STEPS+1];
	logic [63:0]      ad_s   [bc_pkg::DIV_STEPS+1];
	logic             neg_s  [bc_pkg::DIV_STEPS+1];
	bc_pkg::bc_side_t side_s [bc_pkg::DIV_STEPS+1];
	logic [63:0]      quot_q;
	bc_pkg::bc_side_t side_q;

	// take magnitudes, remember the sign of the quotient
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			nq_s[0]   <= num[63] ? 64'd0 - num : num;
			ad_s[0]   <= den[63] ? 64'd0 - den : den;
			neg_s[0]  <= num[63] ^ den[63];
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 1; k <= bc_pkg::DIV_STEPS; k++) begin : g_step
		logic [64:0] trial;
		logic [64:0] diff;
		assign trial = {rem_s[k-1], nq_s[k-1][63]};
		assign diff  = trial - {1'b0, ad_s[k-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (!diff[64]) begin
					rem_s[k] <= diff[63:0];
					nq_s[k]  <= {nq_s[k-1][62:0], 1'b1};
				end else begin
					rem_s[k] <= trial[63:0];
					nq_s[k]  <= {nq_s[k-1][62:0], 1'b0};
				end
				ad_s[k]   <= ad_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quot_q <= neg_s[bc_pkg::DIV_STEPS] ? 64'd0 - nq_s[bc_pkg::DIV_STEPS]
			                                   : nq_s[bc_pkg::DIV_STEPS];
			side_q <= side_s[bc_pkg::DIV_STEPS];
		end
	end

	assign quot     = quot_q;
	assign side_out = side_q;

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the barometer compensation pipeline.
`timescale 1ns / 100ps

module tb;

	localparam logic [bc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = bc_pkg::PIPE_DEPTH + 20;

	typedef struct {
		logic [15:0] temp;
		logic [31:0] pres;
		logic        inv;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [19:0] raw_temp = '0;
	logic [19:0] raw_pressure = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [15:0] temp_centi;
	logic [31:0] pressure_q24_8;
	logic pressure_invalid;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [bc_pkg::CFG_IDX_W-1:0] cfg_index = bc_pkg::CFG_T1;
	logic [31:0] cfg_data = '0;

	// Calibration copy kept in step with the block, and the expected readings.
	logic [31:0] cal [7];
	reading_t    pending_readings [$];
	int          mismatches = 0;
	int          cycles = 0;
	int          stall_left = 0;
	bit          no_idle = 1'b0;
	bit          rx_hold = 1'b0;

	barometer_compensation i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.raw_temp(raw_temp), .raw_pressure(raw_pressure),
		.out_valid(out_valid), .out_ready(out_ready),
		.temp_centi(temp_centi), .pressure_q24_8(pressure_q24_8),
		.pressure_invalid(pressure_invalid),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [31:0] shr32(input logic signed [31:0] x, input int s);
		return x >>> s;
	endfunction

	function automatic logic [63:0] shr64(input logic signed [63:0] x, input int s);
		return x >>> s;
	endfunction

	function automatic logic [63:0] lo_word(input logic [31:0] r);
		return {{48{r[15]}}, r[15:0]};
	endfunction

	function automatic logic [63:0] hi_word(input logic [31:0] r);
		return {{48{r[31]}}, r[31:16]};
	endfunction

	// Compensate one raw pair with the current calibration copy.
	function automatic reading_t compensate(input logic [19:0] rt, input logic [19:0] rp);
		reading_t r;
		logic [31:0] t1, t2, t3, d1, d2, a1, a2, tf, tc, m;
		logic [63:0] v1, v2, p, m64, an, ad, q;
		t1 = {16'd0, cal[bc_pkg::CFG_T1][15:0]};
		t2 = 32'(lo_word(cal[bc_pkg::CFG_T2_T3]));
		t3 = 32'(hi_word(cal[bc_pkg::CFG_T2_T3]));
		// temperature path wraps at 32 bits
		d1 = {15'd0, rt[19:3]} - (t1 << 1);
		m = d1 * t2;
		a1 = shr32(m, 11);
		d2 = {16'd0, rt[19:4]} - t1;
		m = d2 * d2;
		m = shr32(m, 12) * t3;
		a2 = shr32(m, 14);
		tf = a1 + a2;
		m = tf * 32'd5 + 32'd128;
		tc = shr32(m, 8);
		if ($signed(tc) < -32768) r.temp = 16'h8000;
		else if ($signed(tc) > 32767) r.temp = 16'h7FFF;
		else r.temp = tc[15:0];
		// pressure path wraps at 64 bits
		v1 = {{32{tf[31]}}, tf} - 64'd128000;
		v2 = v1 * v1 * lo_word(cal[bc_pkg::CFG_P6_P7]);
		v2 = v2 + ((v1 * hi_word(cal[bc_pkg::CFG_P4_P5])) << 17);
		v2 = v2 + (lo_word(cal[bc_pkg::CFG_P4_P5]) << 35);
		m64 = v1 * v1 * hi_word(cal[bc_pkg::CFG_P2_P3]);
		v1 = shr64(m64, 8) + ((v1 * lo_word(cal[bc_pkg::CFG_P2_P3])) << 12);
		m64 = ((64'd1 << 47) + v1) * {48'd0, cal[bc_pkg::CFG_P1][15:0]};
		v1 = shr64(m64, 33);
		if (v1 == 64'd0) begin
			r.pres = 32'd0;
			r.inv = 1'b1;
		end else begin
			p = 64'd1048576 - {44'd0, rp};
			m64 = ((p << 31) - v2) * 64'd3125;
			// signed divide toward zero; most negative by -1 wraps
			an = m64[63] ? -m64 : m64;
			ad = v1[63] ? -v1 : v1;
			q = an / ad;
			p = (m64[63] != v1[63]) ? -q : q;
			m64 = shr64(p, 13);
			m64 = hi_word(cal[bc_pkg::CFG_P8_P9]) * m64 * m64;
			v1 = shr64(m64, 25);
			m64 = lo_word(cal[bc_pkg::CFG_P8_P9]) * p;
			v2 = shr64(m64, 19);
			m64 = p + v1 + v2;
			p = shr64(m64, 8) + (hi_word(cal[bc_pkg::CFG_P6_P7]) << 4);
			if (p[63]) r.pres = 32'd0;
			else if (p[63:32] != 32'd0) r.pres = 32'hFFFF_FFFF;
			else r.pres = p[31:0];
			r.inv = 1'b0;
		end
		return r;
	endfunction

	function automatic int draw_wait();
		return no_idle ? 0 : $urandom_range(0, 12);
	endfunction

	// Predict on every accepted request.
	always @(posedge clk) begin
		if (in_valid && in_ready)
			pending_readings.push_back(compensate(raw_temp, raw_pressure));
	end

	// Compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		reading_t e;
		if (out_valid && out_ready) begin
			if (pending_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result temp=%0d pres=%0d inv=%0b",
						$signed(temp_centi), pressure_q24_8, pressure_invalid);
			end else begin
				e = pending_readings.pop_front();
				if (e.temp !== temp_centi || e.pres !== pressure_q24_8
						|| e.inv !== pressure_invalid) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp temp=%0d pres=%0d inv=%0b got temp=%0d pres=%0d inv=%0b",
							$signed(e.temp), e.pres, e.inv,
							$signed(temp_centi), pressure_q24_8, pressure_invalid);
				end
			end
		end
	end

	// Receiver: random stall after each result, or a long hold when asked.
	always @(posedge clk) begin
		int w;
		if (rx_hold) begin
			out_ready <= 1'b0;
		end else if (out_valid && out_ready) begin
			w = draw_wait();
			stall_left <= w;
			out_ready <= (w == 0);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= (stall_left == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Offer one raw pair after a random gap and hold it until accepted.
	task automatic send_reading(input logic [19:0] rt, input logic [19:0] rp);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_temp <= rt;
		raw_pressure <= rp;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Drop valid and wait for every prediction to be matched, then let the pipe settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cal(input logic [bc_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == bc_pkg::CFG_T1 || idx == bc_pkg::CFG_P1) cal[idx] = {16'd0, data[15:0]};
		else if (idx != CFG_UNUSED) cal[idx] = data;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_cal(input logic [31:0] t1, t23, p1, p23, p45, p67, p89);
		wait_idle();
		write_cal(bc_pkg::CFG_T1, t1);
		write_cal(bc_pkg::CFG_T2_T3, t23);
		write_cal(bc_pkg::CFG_P1, p1);
		write_cal(bc_pkg::CFG_P2_P3, p23);
		write_cal(bc_pkg::CFG_P4_P5, p45);
		write_cal(bc_pkg::CFG_P6_P7, p67);
		write_cal(bc_pkg::CFG_P8_P9, p89);
	endtask

	task automatic load_stock_cal();
		load_cal(32'd27504, {16'hFC18, 16'd26435}, 32'd36477, {16'd3024, 16'hD643},
			{16'd140, 16'd2855}, {16'd15500, 16'hFFF9}, {16'd6000, 16'hC6F8});
	endtask

	// Zeroed calibration after reset: divisor is zero, so every pressure is invalid.
	task automatic test_reset_cal();
		send_reading(20'h00000, 20'h00000);
		send_reading(20'hFFFFF, 20'hFFFFF);
		send_reading(20'h5A5A5, 20'hA5A5A);
	endtask

	// Stock calibration against the extremes of both raw readings.
	task automatic test_stock_extremes();
		load_stock_cal();
		send_reading(20'd519888, 20'd415148);
		send_reading(20'h00000, 20'h00000);
		send_reading(20'hFFFFF, 20'hFFFFF);
		send_reading(20'h00000, 20'hFFFFF);
		send_reading(20'hFFFFF, 20'h00000);
		send_reading(20'h80000, 20'h80000);
		send_reading(20'h7FFFF, 20'h00001);
	endtask

	// Extreme calibration words, masking of the 16-bit registers, unknown index, zeroed P1.
	task automatic test_extreme_cal();
		load_cal('1, '1, '1, '1, '1, '1, '1);
		send_reading(20'hFFFFF, 20'h00000);
		send_reading(20'h00000, 20'hFFFFF);
		load_cal(32'hABCD_FFFF, 32'h7FFF_8000, 32'h1234_FFFF, 32'h8000_7FFF,
			32'h7FFF_7FFF, 32'h8000_8000, 32'h7FFF_8000);
		send_reading(20'hFFFFF, 20'hFFFFF);
		send_reading(20'h00000, 20'h00000);
		send_reading(20'h12345, 20'h54321);
		load_stock_cal();
		wait_idle();
		write_cal(CFG_UNUSED, 32'hFFFF_FFFF);
		send_reading(20'd519888, 20'd415148);
		// zero P1 on a sane setup: divisor vanishes mid-configuration
		wait_idle();
		write_cal(bc_pkg::CFG_P1, 32'd0);
		send_reading(20'd519888, 20'd415148);
		send_reading(20'hFFFFF, 20'h00000);
	endtask

	// Random calibration sets, half near the stock words, half anything.
	task automatic test_random_cal();
		logic [31:0] r [7];
		for (int s = 0; s < 10; s++) begin
			if (s % 2 == 0) begin
				r[0] = 27504 + $urandom_range(0, 4000) - 2000;
				r[1] = {16'hFC18 + 16'($urandom_range(0, 200)), 16'd26435 + 16'($urandom_range(0, 2000))};
				r[2] = 36477 + $urandom_range(0, 4000) - 2000;
				r[3] = {16'd3024 + 16'($urandom_range(0, 500)), 16'hD643 + 16'($urandom_range(0, 500))};
				r[4] = {16'd140 + 16'($urandom_range(0, 50)), 16'd2855 + 16'($urandom_range(0, 500))};
				r[5] = {16'd15500 + 16'($urandom_range(0, 500)), 16'hFFF9 + 16'($urandom_range(0, 10))};
				r[6] = {16'd6000 + 16'($urandom_range(0, 500)), 16'hC6F8 + 16'($urandom_range(0, 500))};
			end else begin
				foreach (r[i]) r[i] = $urandom();
			end
			if (s == 7) r[2] = 32'd0;
			load_cal(r[0], r[1], r[2], r[3], r[4], r[5], r[6]);
			no_idle = (s % 3 == 1);
			for (int k = 0; k < 105; k++) begin
				if ($urandom_range(0, 3) != 0)
					send_reading(20'd380000 + 20'($urandom_range(0, 280000)),
						20'd200000 + 20'($urandom_range(0, 400000)));
				else
					send_reading(20'($urandom()), 20'($urandom()));
			end
			no_idle = 1'b0;
		end
	endtask

	// Hold the receiver for a long stretch while requests keep coming.
	task automatic test_backpressure();
		load_stock_cal();
		no_idle = 1'b1;
		fork
			begin
				@(posedge clk);
				rx_hold <= 1'b1;
				repeat (400) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		for (int k = 0; k < 200; k++)
			send_reading(20'($urandom()), 20'($urandom()));
		no_idle = 1'b0;
	endtask

	// Pause the sender until the pipe is empty, then resume.
	task automatic test_drain_pause();
		for (int k = 0; k < 30; k++) send_reading(20'($urandom()), 20'($urandom()));
		wait_idle();
		for (int k = 0; k < 30; k++) send_reading(20'($urandom()), 20'($urandom()));
	endtask

	initial begin
		foreach (cal[i]) cal[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_cal();
		test_stock_extremes();
		test_extreme_cal();
		test_random_cal();
		test_backpressure();
		test_drain_pause();
		wait_idle();
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/bc_pkg.sv
src/bc_mul64.sv
src/bc_div.sv
src/barometer_compensation.sv
verif/tb.sv
